// ----- hw/rtl/mt19937_random_generator_assert.svh -----
// assertion macros for the mt19937 generator
`ifndef MT19937_RANDOM_GENERATOR_ASSERT_SVH
`define MT19937_RANDOM_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MT_ASSERT_IMP(label, clk, rst, ante, cons)
`define MT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/mt_pkg.sv -----
// ----------------------------------------------------------------------------
// mt_pkg
// shared types and constants of the mt19937 generator
// ----------------------------------------------------------------------------
`default_nettype none
package mt_pkg;
   localparam int unsigned N_WORDS   = 624;
   localparam int unsigned M_OFFSET  = 397;
   localparam int unsigned IDX_W     = 10;
   localparam logic [31:0] TWIST_XOR = 32'h9908b0df;
   localparam logic [31:0] TEMPER_B  = 32'h9d2c5680;
   localparam logic [31:0] TEMPER_C  = 32'hefc60000;
   localparam logic [31:0] SEED_MULT = 32'd1812433253;
   localparam logic [31:0] ZERO_SEED = 32'd4357;

   localparam logic [1:0] OP_RESEED = 2'd0;
   localparam logic [1:0] OP_DRAW   = 2'd1;
   localparam logic [1:0] OP_RANGE  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // command word between front and back
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] seed;
      logic [31:0] base;
      logic [31:0] span;
   } cmd_type;

   function automatic logic [31:0] temper(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/mt_front.sv -----
// ----------------------------------------------------------------------------
// mt_front
// takes commands, drops unused codes, computes the range distance and
// queues commands for the back end (two entries)
// ----------------------------------------------------------------------------
`default_nettype none
module mt_front import mt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  op,
   input  wire logic [31:0] seed,
   input  wire logic [31:0] range_begin,
   input  wire logic [31:0] range_end,
   output logic             cmd_valid,
   output cmd_type          cmd,
   input  wire logic        cmd_take
);
   cmd_type    q_ff [2];
   cmd_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    c;

   assign busy      = (cnt_ff == 2'd2);
   assign push      = start && !busy && (op != OP_UNUSED);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[0];

   always_comb begin
      c.op   = op;
      c.seed = (seed == 32'd0) ? ZERO_SEED : seed;
      c.base = range_begin;
      c.span = range_end - range_begin;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (cmd_take) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = c;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/mt_divider.sv -----
// ----------------------------------------------------------------------------
// mt_divider
// restoring divider, 33-bit dividend by 32-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none
module mt_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go,
   input  wire logic [32:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [32:0]      quotient,
   output logic [31:0]      remainder
);
   logic [32:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff;
   logic [5:0]  n_ff, n_in;
   logic        run_ff, run_in;
   logic [33:0] sh;

   assign quotient  = q_ff;
   assign remainder = r_ff[31:0];
   assign done      = run_ff && (n_ff == 6'd0);

   always_comb begin
      q_in   = q_ff;
      r_in   = r_ff;
      n_in   = n_ff;
      run_in = run_ff;
      sh     = {r_ff, q_ff[32]};
      if (go) begin
         q_in   = dividend;
         r_in   = 33'd0;
         n_in   = 6'd33;
         run_in = 1'b1;
      end else if (run_ff && n_ff != 6'd0) begin
         if (sh >= {2'b00, d_ff}) begin
            r_in = 33'(sh - {2'b00, d_ff});
            q_in = {q_ff[31:0], 1'b1};
         end else begin
            r_in = sh[32:0];
            q_in = {q_ff[31:0], 1'b0};
         end
         n_in = n_ff - 6'd1;
      end else if (done) begin
         run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      if (go) d_ff <= divisor;
      if (reset) begin
         n_ff   <= 6'd0;
         run_ff <= 1'b0;
      end else begin
         n_ff   <= n_in;
         run_ff <= run_in;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/mt_back.sv -----
// ----------------------------------------------------------------------------
// mt_back
// state memory, reseed sweep, twist sweep, tempering and range reduction
// ----------------------------------------------------------------------------
`default_nettype none
`include "mt19937_random_generator_assert.svh"
module mt_back import mt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   input  wire cmd_type     cmd,
   output logic             cmd_take,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_value
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SEED  = 4'd1;
   localparam logic [3:0] S_LIM   = 4'd2;
   localparam logic [3:0] S_LIMW  = 4'd3;
   localparam logic [3:0] S_FETCH = 4'd4;
   localparam logic [3:0] S_TW0   = 4'd5;
   localparam logic [3:0] S_TW1   = 4'd6;
   localparam logic [3:0] S_TW2   = 4'd7;
   localparam logic [3:0] S_TW3   = 4'd8;
   localparam logic [3:0] S_RD    = 4'd9;
   localparam logic [3:0] S_RD2   = 4'd10;
   localparam logic [3:0] S_MODW  = 4'd11;
   localparam logic [3:0] S_SEED2 = 4'd12;

   localparam logic [IDX_W-1:0] LAST = IDX_W'(N_WORDS - 1);

   logic [31:0] mem [N_WORDS];
   logic [31:0] rd_ff;
   logic [IDX_W-1:0] ra;
   logic        we;
   logic [IDX_W-1:0] wa;
   logic [31:0] wd;
   logic [IDX_W-1:0] tap;

   logic [3:0]  st_ff, st_in;
   logic [IDX_W-1:0] idx_ff, idx_in;   // draw pointer, N_WORDS = used up
   logic [IDX_W-1:0] k_ff, k_in;
   logic [31:0] a_ff, a_in;            // word k / previous seed word
   logic [31:0] b_ff, b_in;            // word k+1
   logic [31:0] m_ff, m_in;            // product register
   logic [31:0] lim_ff, lim_in;
   cmd_type     c_ff, c_in;
   logic        out_ff, out_in;
   logic [31:0] val_ff, val_in;

   logic        dgo, ddone;
   logic [32:0] dq;
   logic [31:0] dr;
   logic [32:0] dnd;
   logic [31:0] y, w;

   // divisor is latched on go, so take it from the command being loaded
   mt_divider u_div (
      .clock(clock), .reset(reset), .go(dgo), .dividend(dnd), .divisor(c_in.span),
      .done(ddone), .quotient(dq), .remainder(dr)
   );

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   assign rsp_strobe = out_ff;
   assign rsp_value  = val_ff;

   always_comb begin
      st_in = st_ff; idx_in = idx_ff; k_in = k_ff; a_in = a_ff; b_in = b_ff;
      m_in = m_ff; lim_in = lim_ff; c_in = c_ff; out_in = 1'b0; val_in = val_ff;
      cmd_take = 1'b0; we = 1'b0; wa = k_ff; wd = 32'd0; ra = k_ff;
      dgo = 1'b0; dnd = 33'h1_0000_0000;
      y = {a_ff[31], b_ff[30:0]};
      w = rd_ff ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
      tap = (k_ff >= IDX_W'(N_WORDS - M_OFFSET)) ?
            IDX_W'(k_ff - IDX_W'(N_WORDS - M_OFFSET)) : IDX_W'(k_ff + IDX_W'(M_OFFSET));
      case (st_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               c_in = cmd;
               if (cmd.op == OP_RESEED) begin
                  we = 1'b1; wa = '0; wd = cmd.seed;
                  a_in = cmd.seed; k_in = IDX_W'(1);
                  st_in = S_SEED;
               end else if (cmd.op == OP_RANGE) begin
                  if (cmd.span == 32'd0) begin
                     out_in = 1'b1; val_in = cmd.base;
                  end else begin
                     dgo = 1'b1; dnd = 33'h1_0000_0000;
                     st_in = S_LIM;
                  end
               end else begin
                  st_in = S_FETCH;
               end
            end
         end
         S_SEED: begin
            m_in = SEED_MULT * (a_ff ^ (a_ff >> 30));
            st_in = S_SEED2;
         end
         S_SEED2: begin
            we = 1'b1; wd = m_ff + 32'(k_ff);
            a_in = m_ff + 32'(k_ff);
            k_in = k_ff + IDX_W'(1);
            st_in = (k_ff == LAST) ? S_IDLE : S_SEED;
            if (k_ff == LAST) idx_in = IDX_W'(N_WORDS);
         end
         S_LIM: begin
            if (ddone) begin
               // quotient times distance, wraps to zero when distance divides 2^32
               lim_in = dq[31:0] * c_ff.span;
               st_in = S_LIMW;
            end
         end
         S_LIMW: st_in = S_FETCH;
         S_FETCH: begin
            if (idx_ff == IDX_W'(N_WORDS)) begin
               k_in = '0; ra = '0; st_in = S_TW0;
            end else begin
               ra = idx_ff; st_in = S_RD;
            end
         end
         S_TW0: begin
            ra = (k_ff == LAST) ? '0 : k_ff + IDX_W'(1);
            if (k_ff == '0) a_in = rd_ff;
            st_in = S_TW1;
         end
         S_TW1: begin
            b_in = rd_ff;
            ra = tap;
            st_in = S_TW2;
         end
         S_TW2: begin
            // keep the tap word in the read register
            ra = tap;
            st_in = S_TW3;
         end
         S_TW3: begin
            we = 1'b1; wd = w;
            a_in = b_ff;
            k_in = k_ff + IDX_W'(1);
            // word 0 was rewritten, so the wrap reads hold the new value
            ra = (k_ff == LAST) ? '0 : k_ff + IDX_W'(1);
            if (k_ff == LAST) begin
               idx_in = '0; st_in = S_FETCH;
            end else st_in = S_TW0;
         end
         S_RD: begin
            ra = idx_ff;
            st_in = S_RD2;
         end
         S_RD2: begin
            idx_in = idx_ff + IDX_W'(1);
            val_in = temper(rd_ff);
            if (c_ff.op == OP_DRAW) begin
               out_in = 1'b1; st_in = S_IDLE;
            end else if (lim_ff != 32'd0 && temper(rd_ff) >= lim_ff) begin
               st_in = S_FETCH;
            end else begin
               dgo = 1'b1; dnd = {1'b0, temper(rd_ff)};
               st_in = S_MODW;
            end
         end
         S_MODW: begin
            if (ddone) begin
               out_in = 1'b1; val_in = c_ff.base + dr; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in; a_ff <= a_in; b_ff <= b_in; m_ff <= m_in;
      lim_ff <= lim_in; c_ff <= c_in; val_ff <= val_in;
      if (reset) begin
         st_ff  <= S_IDLE;
         idx_ff <= IDX_W'(N_WORDS);
         out_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         idx_ff <= idx_in;
         out_ff <= out_in;
      end
   end

   `MT_ASSERT_IMP(a_idx_range, clock, reset, 1'b1, idx_ff <= IDX_W'(N_WORDS))
   `MT_ASSERT_NXT(a_take_leaves_idle, clock, reset, cmd_take && cmd.op == OP_RESEED, st_ff == S_SEED)
   `MT_ASSERT_IMP(a_take_only_idle, clock, reset, cmd_take, st_ff == S_IDLE)
endmodule
`default_nettype wire

// ----- hw/rtl/mt19937_random_generator.sv -----
// ----------------------------------------------------------------------------
// mt19937_random_generator
// 32-bit mersenne twister with reseed, word draw and range draw
// ----------------------------------------------------------------------------
// Commands enter when start is high and busy low; a two-entry queue lets
// up to two wait while one runs. A reseed writes each state word with one
// multiply. A draw tempers the next word in S_FETCH, S_RD and S_RD2, first
// twisting all 624 words (S_TW0 to S_TW3 per word) when they are used up.
// A range draw with a nonzero distance adds the limit division and the
// final modulo on the single bit-serial divider, repeating the draw on a
// rejection. Each result appears once on rsp_value with rsp_strobe high
// for one cycle; the receiver cannot stall it. Reseed before the first draw.
`default_nettype none
module mt19937_random_generator import mt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_seed,
   input  wire logic signed [31:0] req_range_begin,
   input  wire logic signed [31:0] req_range_end,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_value
);
   logic    cmd_valid, cmd_take;
   cmd_type cmd;

   mt_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .op(req_op),
      .seed(req_seed), .range_begin(req_range_begin), .range_end(req_range_end),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
   );

   mt_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_take(cmd_take), .rsp_strobe(rsp_strobe), .rsp_value(rsp_value)
   );
endmodule
`default_nettype wire

// ----- tb/tb_mt19937_random_generator.sv -----
// ----------------------------------------------------------------------------
// tb_mt19937_random_generator
// self-checking bench for the mt19937 generator: directed and random
// reseed, word draw and range draw commands checked against a local twister
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_mt19937_random_generator import mt_pkg::*; ();

   localparam int         RANDOM_ITEMS = 1325;
   localparam int         CALM_ITEMS   = 200;
   localparam int         STALL_LIMIT  = 20000;
   localparam int         DRAIN_CYCLES = 3000;

   class draw_checker;
      logic [31:0] words[N_WORDS];
      int unsigned next_idx;
      logic [31:0] expected_values[$];
      int          mismatches;

      function new();
         next_idx   = N_WORDS;
         mismatches = 0;
      endfunction

      function void reseed_words(logic [31:0] s);
         logic [31:0] p;
         words[0] = (s == 32'd0) ? ZERO_SEED : s;
         for (int i = 1; i < N_WORDS; i++) begin
            p = words[i-1];
            words[i] = SEED_MULT * (p ^ {30'd0, p[31:30]}) + 32'(i);
         end
         next_idx = N_WORDS;
      endfunction

      function void twist_words();
         logic [31:0] y;
         logic [31:0] w;
         for (int k = 0; k < N_WORDS; k++) begin
            y = {words[k][31], words[(k + 1) % N_WORDS][30:0]};
            w = words[(k + M_OFFSET) % N_WORDS] ^ {1'b0, y[31:1]};
            if (y[0]) w = w ^ TWIST_XOR;
            words[k] = w;
         end
         next_idx = 0;
      endfunction

      function logic [31:0] next_tempered();
         logic [31:0] t;
         if (next_idx >= N_WORDS) twist_words();
         t = words[next_idx];
         next_idx++;
         t = t ^ {11'd0, t[31:11]};
         t = t ^ ({t[24:0], 7'd0} & TEMPER_B);
         t = t ^ ({t[16:0], 15'd0} & TEMPER_C);
         t = t ^ {18'd0, t[31:18]};
         return t;
      endfunction

      // called once per accepted command word
      function void note_word(logic [1:0] op, logic [31:0] seed,
                              logic [31:0] lo, logic [31:0] hi);
         logic [31:0] span;
         logic [31:0] cut;
         logic [31:0] r;
         case (op)
            OP_RESEED: reseed_words(seed);
            OP_DRAW:   expected_values.push_back(next_tempered());
            OP_RANGE: begin
               span = hi - lo;
               r    = 32'd0;
               if (span != 32'd0) begin
                  cut = 32'((64'h1_0000_0000 / span) * span);
                  do r = next_tempered(); while (cut != 32'd0 && r >= cut);
                  r = r % span;
               end
               expected_values.push_back(lo + r);
            end
            default: ;
         endcase
      endfunction

      function void check_word(logic [31:0] got);
         logic [31:0] want;
         if (expected_values.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
            return;
         end
         want = expected_values.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("value mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_op = OP_RESEED;
   logic [31:0] req_seed = '0;
   logic signed [31:0] req_range_begin = '0;
   logic signed [31:0] req_range_end = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [31:0] rsp_value;

   draw_checker checker_h = new();
   int          stall_count = 0;
   bit          calm = 1'b0;

   mt19937_random_generator i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_seed(req_seed),
      .req_range_begin(req_range_begin), .req_range_end(req_range_end),
      .rsp_strobe(rsp_strobe), .rsp_value(rsp_value)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) checker_h.check_word(rsp_value);
      if (!reset && ((start && !busy) || rsp_strobe)) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] op, logic [31:0] seed,
                            logic [31:0] lo, logic [31:0] hi);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_op          <= op;
      req_seed        <= seed;
      req_range_begin <= lo;
      req_range_end   <= hi;
      @(posedge clock);
      while (busy) @(posedge clock);
      checker_h.note_word(op, seed, lo, hi);
   endtask

   task automatic send_random();
      int          pick;
      logic [31:0] lo;
      logic [31:0] span;
      pick = $urandom_range(0, 99);
      lo   = $urandom;
      case ($urandom_range(0, 4))
         0: span = $urandom_range(1, 40);
         1: span = 32'd1 << $urandom_range(0, 31);
         2: span = 32'hc000_0000 + $urandom_range(0, 255);
         3: span = '0;
         default: span = $urandom;
      endcase
      if (pick < 3) send_word(OP_RESEED, $urandom, $urandom, $urandom);
      else if (pick < 5) send_word(OP_UNUSED, $urandom, $urandom, $urandom);
      else if (pick < 50) send_word(OP_DRAW, $urandom, $urandom, $urandom);
      else send_word(OP_RANGE, $urandom, lo, lo + span);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero seed stands for the default seed
      send_word(OP_RESEED, 32'd0, '0, '0);
      send_word(OP_DRAW, '0, '0, '0);
      send_word(OP_DRAW, '1, '1, '1);
      send_word(OP_UNUSED, '1, '1, '1);
      send_word(OP_RESEED, 32'hffff_ffff, '0, '0);
      send_word(OP_DRAW, '0, '0, '0);
      send_word(OP_RANGE, '0, 32'd5, 32'd5);
      send_word(OP_RANGE, '0, 32'h8000_0000, 32'h8000_0000);
      send_word(OP_RANGE, '0, 32'h7fff_ffff, 32'h8000_0000);
      send_word(OP_RANGE, '0, 32'h8000_0000, 32'h7fff_ffff);
      send_word(OP_RANGE, '0, 32'h7fff_ffff, 32'h8000_0000 + 32'h8000_0000 - 1);
      send_word(OP_RANGE, '0, 32'hffff_fff0, 32'h0000_0010);
      send_word(OP_RANGE, '0, 32'd0, 32'd1 << 31);
      send_word(OP_RANGE, '0, 32'd0, 32'hc000_0000);
      send_word(OP_RANGE, '0, 32'd100, 32'd107);
      send_word(OP_RANGE, '0, 32'd0, 32'hffff_ffff);
      send_word(OP_RESEED, 32'h0000_0001, '0, '0);
      send_word(OP_RANGE, '0, 32'h1234_5678, 32'h1234_5677);
      send_word(OP_DRAW, '0, '0, '0);
      send_word(OP_RESEED, 32'h8000_0000, '0, '0);
      send_word(OP_RANGE, '0, 32'h0, 32'h3);
      send_word(OP_UNUSED, '0, '0, '0);
      send_word(OP_DRAW, '0, '0, '0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         send_random();
      end
      start <= 1'b0;

      while (checker_h.expected_values.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (checker_h.mismatches == 0 && checker_h.expected_values.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
